// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rau_pkg.sv =====
// Types, codes and widths of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

	localparam int VALUE_BITS = 32;
	localparam int PROD_BITS  = 2 * VALUE_BITS;
	localparam int DIV_BITS   = 2 * VALUE_BITS + 1;
	localparam int CNT_BITS   = $clog2(DIV_BITS + 1);
	localparam int SHIFT_BITS = $clog2(VALUE_BITS);

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_SUB    = 3'd1;
	localparam logic [2:0] CMD_MUL    = 3'd2;
	localparam logic [2:0] CMD_DIV    = 3'd3;
	localparam logic [2:0] CMD_NEG    = 3'd4;
	localparam logic [2:0] CMD_RECIP  = 3'd5;
	localparam logic [2:0] CMD_REDUCE = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]                   command;
		logic signed [VALUE_BITS-1:0] a_num;
		logic [VALUE_BITS-1:0]        a_den;
		logic signed [VALUE_BITS-1:0] b_num;
		logic [VALUE_BITS-1:0]        b_den;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] res_num;
		logic [VALUE_BITS-1:0]        res_den;
		logic [1:0]                   status;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: sequencer with bit-serial gcd, divide and multiply units.
`default_nettype none

// Usage
//   Command channel: drive req and raise start; the transfer happens at the rising
//   edge where start is high and busy is low. busy stays high until the result
//   has been shown; a new start is taken in the very cycle the result strobe is up.
//   Result channel: done is high for exactly one cycle with rsp valid; the receiver
//   cannot stall it and must take the transfer in that cycle.
// Sequence
//   Operands are reduced first, then the command runs on shared serial units:
//   a binary gcd (one subtract-and-halve step per cycle), two restoring divider
//   lanes (one quotient bit per cycle, on operand-width dividends and on
//   2*VALUE_BITS+1-bit sums) and two shift-add multiplier lanes (one bit per
//   cycle). A zero denominator ends the command at once. Negate, reciprocal
//   and reduce run one gcd. Divide by a zero fraction runs two gcds. Multiply
//   and divide run four gcds. Add and subtract run four gcds, or three when
//   the sum is zero. One command is in flight at a time.
// Reset
//   arst_n clears the sequencer to idle and drops done; no clearing pass is needed.
module rational_arithmetic_unit_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rau_pkg::req_t req,
	output logic               done,
	output rau_pkg::rsp_t      rsp
);
	import rau_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_RA, S_RA2, S_RB, S_RB2,
		S_AD1, S_AD2, S_AD3, S_AD4, S_AD5, S_AD6, S_AD7, S_AD8,
		S_MU2, S_MU3, S_MU4, S_MU5, S_MU6,
		S_GCD, S_DIV, S_MUL, S_EMIT
	} state_t;

	localparam logic [DIV_BITS-1:0] MAG_MAX_POS = (DIV_BITS'(1) << (VALUE_BITS - 1)) - 1'b1;
	localparam logic [DIV_BITS-1:0] MAG_MAX_NEG = DIV_BITS'(1) << (VALUE_BITS - 1);
	localparam logic [DIV_BITS-VALUE_BITS-1:0] PAD_Z = '0;

	state_t state_q, ret_q;
	logic [2:0] cmd_q;
	logic an_q, bn_q, neg_q;
	logic [VALUE_BITS-1:0] am_q, ad_q, bm_q, bd_q;
	logic [VALUE_BITS-1:0] g_q, g1_q;
	logic [DIV_BITS-1:0] t_q, rm_q;
	logic [PROD_BITS-1:0] rd_q;
	logic [1:0] st_q;
	// gcd unit
	logic [VALUE_BITS-1:0] gx_q, gy_q;
	logic [SHIFT_BITS-1:0] gk_q;
	// divider lanes
	logic [DIV_BITS-1:0] n0_q, n1_q;
	logic [VALUE_BITS-1:0] r0_q, r1_q, dv_q;
	logic [CNT_BITS-1:0] cnt_q;
	// multiplier lanes
	logic [VALUE_BITS-1:0] c0_q, c1_q, p0_q, p1_q, h0_q, h1_q;
	logic done_q;
	rsp_t rsp_q;

	logic [VALUE_BITS:0] dt0, dt1, ms0, ms1;
	logic dge0, dge1;
	logic [PROD_BITS-1:0] px, py;
	logic [DIV_BITS-1:0] add_t;
	logic add_neg;
	logic [VALUE_BITS-1:0] qa0, qa1;
	logic ovf;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_comb begin
		// one restoring step per divider lane
		dt0  = {r0_q, n0_q[DIV_BITS-1]};
		dt1  = {r1_q, n1_q[DIV_BITS-1]};
		dge0 = (dt0 >= {1'b0, dv_q});
		dge1 = (dt1 >= {1'b0, dv_q});
		// one shift-add step per multiplier lane
		ms0 = {1'b0, h0_q} + (p0_q[0] ? {1'b0, c0_q} : '0);
		ms1 = {1'b0, h1_q} + (p1_q[0] ? {1'b0, c1_q} : '0);
		// signed sum of the two cross products
		px = {h0_q, p0_q};
		py = {h1_q, p1_q};
		if (an_q == bn_q) begin
			add_t   = {1'b0, px} + {1'b0, py};
			add_neg = an_q;
		end else if (px >= py) begin
			add_t   = {1'b0, px - py};
			add_neg = an_q;
		end else begin
			add_t   = {1'b0, py - px};
			add_neg = bn_q;
		end
		qa0 = n0_q[VALUE_BITS-1:0];
		qa1 = n1_q[VALUE_BITS-1:0];
		ovf = (rm_q > (neg_q ? MAG_MAX_NEG : MAG_MAX_POS)) ||
			(rd_q[PROD_BITS-1:VALUE_BITS] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			cmd_q   <= '0;
			an_q    <= 1'b0;
			bn_q    <= 1'b0;
			neg_q   <= 1'b0;
			am_q    <= '0;
			ad_q    <= '0;
			bm_q    <= '0;
			bd_q    <= '0;
			g_q     <= '0;
			g1_q    <= '0;
			t_q     <= '0;
			rm_q    <= '0;
			rd_q    <= '0;
			st_q    <= ST_OK;
			gx_q    <= '0;
			gy_q    <= '0;
			gk_q    <= '0;
			n0_q    <= '0;
			n1_q    <= '0;
			r0_q    <= '0;
			r1_q    <= '0;
			dv_q    <= '0;
			cnt_q   <= '0;
			c0_q    <= '0;
			c1_q    <= '0;
			p0_q    <= '0;
			p1_q    <= '0;
			h0_q    <= '0;
			h1_q    <= '0;
		end else begin
			// raise the strobe in the cycle after the emit state
			done_q <= (state_q == S_EMIT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= req.command;
						an_q  <= req.a_num[VALUE_BITS-1];
						bn_q  <= req.b_num[VALUE_BITS-1];
						am_q  <= req.a_num[VALUE_BITS-1] ? VALUE_BITS'(-req.a_num)
							: VALUE_BITS'(req.a_num);
						bm_q  <= req.b_num[VALUE_BITS-1] ? VALUE_BITS'(-req.b_num)
							: VALUE_BITS'(req.b_num);
						ad_q  <= req.a_den;
						bd_q  <= req.b_den;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// zero denominators end the command at once
					if (ad_q == '0 || (cmd_q <= CMD_DIV && bd_q == '0)) begin
						st_q    <= ST_DIVZ;
						state_q <= S_EMIT;
					end else begin
						gx_q <= am_q; gy_q <= ad_q; gk_q <= '0;
						ret_q <= S_RA; state_q <= S_GCD;
					end
				end
				S_RA: begin
					n0_q <= {am_q, PAD_Z}; n1_q <= {ad_q, PAD_Z};
					r0_q <= '0; r1_q <= '0; dv_q <= g_q;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_RA2; state_q <= S_DIV;
				end
				S_RA2: begin
					am_q <= qa0; ad_q <= qa1;
					an_q <= an_q && (qa0 != '0);
					// reciprocal of zero is a division by zero
					st_q <= (cmd_q == CMD_RECIP && qa0 == '0) ? ST_DIVZ : ST_OK;
					if (cmd_q >= CMD_NEG) begin
						state_q <= S_EMIT;
						unique case (cmd_q)
							CMD_NEG: begin
								rm_q <= DIV_BITS'(qa0); rd_q <= PROD_BITS'(qa1);
								neg_q <= !an_q && (qa0 != '0);
							end
							CMD_RECIP: begin
								rm_q <= DIV_BITS'(qa1); rd_q <= PROD_BITS'(qa0);
								neg_q <= an_q;
							end
							CMD_REDUCE: begin
								rm_q <= DIV_BITS'(qa0); rd_q <= PROD_BITS'(qa1);
								neg_q <= an_q && (qa0 != '0);
							end
							default: begin
								rm_q <= DIV_BITS'(qa0); rd_q <= PROD_BITS'(qa1);
								neg_q <= an_q && (qa0 != '0);
							end
						endcase
					end else begin
						gx_q <= bm_q; gy_q <= bd_q; gk_q <= '0;
						ret_q <= S_RB; state_q <= S_GCD;
					end
				end
				S_RB: begin
					n0_q <= {bm_q, PAD_Z}; n1_q <= {bd_q, PAD_Z};
					r0_q <= '0; r1_q <= '0; dv_q <= g_q;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_RB2; state_q <= S_DIV;
				end
				S_RB2: begin
					gk_q <= '0;
					unique case (cmd_q)
						CMD_ADD, CMD_SUB: begin
							bm_q <= qa0; bd_q <= qa1;
							bn_q <= (cmd_q == CMD_SUB) ? (!bn_q && qa0 != '0)
								: (bn_q && qa0 != '0);
							gx_q <= ad_q; gy_q <= qa1;
							ret_q <= S_AD1;
							state_q <= S_GCD;
						end
						CMD_MUL: begin
							bm_q <= qa0; bd_q <= qa1;
							bn_q <= bn_q && (qa0 != '0);
							gx_q <= am_q; gy_q <= qa1;
							ret_q <= S_MU2;
							state_q <= S_GCD;
						end
						default: begin
							// divide: multiply by the reciprocal of b
							if (qa0 == '0) begin
								st_q <= ST_DIVZ;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_GCD;
							end
							bm_q <= qa1; bd_q <= qa0;
							gx_q <= am_q; gy_q <= qa0;
							ret_q <= S_MU2;
						end
					endcase
				end
				S_AD1: begin
					g1_q <= g_q;
					n0_q <= {ad_q, PAD_Z}; n1_q <= {bd_q, PAD_Z};
					r0_q <= '0; r1_q <= '0; dv_q <= g_q;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_AD2; state_q <= S_DIV;
				end
				S_AD2: begin
					ad_q <= qa0;
					c0_q <= am_q; p0_q <= qa1; h0_q <= '0;
					c1_q <= bm_q; p1_q <= qa0; h1_q <= '0;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_AD3; state_q <= S_MUL;
				end
				S_AD3: begin
					t_q <= add_t; neg_q <= add_neg;
					state_q <= S_AD4;
				end
				S_AD4: begin
					if (t_q == '0) begin
						rm_q <= '0; rd_q <= PROD_BITS'(1); neg_q <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						n0_q <= t_q; n1_q <= '0;
						r0_q <= '0; r1_q <= '0; dv_q <= g1_q;
						cnt_q <= CNT_BITS'(DIV_BITS);
						ret_q <= S_AD5; state_q <= S_DIV;
					end
				end
				S_AD5: begin
					gx_q <= r0_q; gy_q <= g1_q; gk_q <= '0;
					ret_q <= S_AD6; state_q <= S_GCD;
				end
				S_AD6: begin
					n0_q <= t_q; n1_q <= {PAD_Z, bd_q};
					r0_q <= '0; r1_q <= '0; dv_q <= g_q;
					cnt_q <= CNT_BITS'(DIV_BITS);
					ret_q <= S_AD7; state_q <= S_DIV;
				end
				S_AD7: begin
					rm_q <= n0_q;
					c0_q <= ad_q; p0_q <= qa1; h0_q <= '0;
					c1_q <= '0; p1_q <= '0; h1_q <= '0;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_AD8; state_q <= S_MUL;
				end
				S_AD8: begin
					rd_q <= {h0_q, p0_q};
					state_q <= S_EMIT;
				end
				S_MU2: begin
					g1_q <= (g_q == '0) ? VALUE_BITS'(1) : g_q;
					gx_q <= bm_q; gy_q <= ad_q; gk_q <= '0;
					ret_q <= S_MU3; state_q <= S_GCD;
				end
				S_MU3: begin
					if (g_q == '0) g_q <= VALUE_BITS'(1);
					n0_q <= {am_q, PAD_Z}; n1_q <= {bd_q, PAD_Z};
					r0_q <= '0; r1_q <= '0; dv_q <= g1_q;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_MU4; state_q <= S_DIV;
				end
				S_MU4: begin
					am_q <= qa0; bd_q <= qa1;
					n0_q <= {bm_q, PAD_Z}; n1_q <= {ad_q, PAD_Z};
					r0_q <= '0; r1_q <= '0; dv_q <= g_q;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_MU5; state_q <= S_DIV;
				end
				S_MU5: begin
					c0_q <= am_q; p0_q <= qa0; h0_q <= '0;
					c1_q <= qa1; p1_q <= bd_q; h1_q <= '0;
					cnt_q <= CNT_BITS'(VALUE_BITS);
					ret_q <= S_MU6; state_q <= S_MUL;
				end
				S_MU6: begin
					rm_q <= DIV_BITS'({h0_q, p0_q});
					rd_q <= {h1_q, p1_q};
					neg_q <= an_q ^ bn_q;
					state_q <= S_EMIT;
				end
				S_GCD: begin
					// binary gcd: halve evens, subtract odds
					priority if (gx_q == '0 || gy_q == '0) begin
						g_q <= (gx_q | gy_q) << gk_q;
						state_q <= ret_q;
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gk_q <= gk_q + 1'b1;
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q >= gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
				S_DIV: begin
					n0_q <= {n0_q[DIV_BITS-2:0], dge0};
					n1_q <= {n1_q[DIV_BITS-2:0], dge1};
					r0_q <= dge0 ? VALUE_BITS'(dt0 - {1'b0, dv_q}) : dt0[VALUE_BITS-1:0];
					r1_q <= dge1 ? VALUE_BITS'(dt1 - {1'b0, dv_q}) : dt1[VALUE_BITS-1:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) state_q <= ret_q;
				end
				S_MUL: begin
					h0_q <= ms0[VALUE_BITS:1]; p0_q <= {ms0[0], p0_q[VALUE_BITS-1:1]};
					h1_q <= ms1[VALUE_BITS:1]; p1_q <= {ms1[0], p1_q[VALUE_BITS-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) state_q <= ret_q;
				end
				S_EMIT: begin
					// range check, then register the result shown with the done strobe
					state_q <= S_IDLE;
					if (st_q != ST_OK || ovf) begin
						rsp_q.res_num <= '0;
						rsp_q.res_den <= '0;
						rsp_q.status  <= (st_q != ST_OK) ? st_q : ST_OVF;
					end else begin
						rsp_q.res_num <= neg_q ? -rm_q[VALUE_BITS-1:0] : rm_q[VALUE_BITS-1:0];
						rsp_q.res_den <= rd_q[VALUE_BITS-1:0];
						rsp_q.status  <= ST_OK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rau_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	`RAU_ASSERT_NXT(a_take_busy, start && !busy, busy, "accepted command did not raise busy")
	`RAU_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
	`RAU_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`RAU_ASSERT_IMP(a_err_zero, done && rsp.status != ST_OK,
		rsp.res_num == '0 && rsp.res_den == '0, "error result not zero")
	`RAU_ASSERT_IMP(a_ok_den, done && rsp.status == ST_OK, rsp.res_den != '0,
		"ok result with zero denominator")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

`default_nettype wire
